// File: hw/rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// shared types and constants of the nearest palette color search block
// ----------------------------------------------------------------------------
package npcs_pkg;

  localparam int PAL_ENTRIES_DEF = 256;
  localparam int IDX_BITS        = 8;
  localparam int COMP_BITS       = 6;
  localparam int COLOR_BITS      = 8;
  localparam int DIST_BITS       = 18;
  localparam int CMD_BITS        = 2;
  localparam int IN_TDATA_W      = 56;
  localparam int OUT_TDATA_W     = 56;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // input request payload, last field in the low bits
  typedef struct packed {
    logic [COLOR_BITS-1:0] query_blue;
    logic [COLOR_BITS-1:0] query_green;
    logic [COLOR_BITS-1:0] query_red;
    logic [COMP_BITS-1:0]  entry_blue;
    logic [COMP_BITS-1:0]  entry_green;
    logic [COMP_BITS-1:0]  entry_red;
    logic [IDX_BITS-1:0]   entry_index;
  } item_t;

  // result payload, last field in the low bits
  typedef struct packed {
    logic [COLOR_BITS-1:0] color_blue;
    logic [COLOR_BITS-1:0] color_green;
    logic [COLOR_BITS-1:0] color_red;
    logic [DIST_BITS-1:0]  match_dist;
    logic [IDX_BITS-1:0]   best_index;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READ_OUT,
    ST_SCAN,
    ST_DRAIN,
    ST_QUERY_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_item;
    logic scan_clr;
    logic scan_rd;
    logic out_load;
    logic out_query;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hw/rtl/npcs_dpath.sv
// ----------------------------------------------------------------------------
// npcs_dpath
// palette memory, distance pipeline, best-match tracking and output register
// ----------------------------------------------------------------------------
module npcs_dpath
  import npcs_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     in_item,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output res_t      out_res
);

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam logic [IDX_BITS:0] ENTRY_LIMIT = (IDX_BITS+1)'(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);

  function automatic logic [2*COLOR_BITS-1:0] sq_diff(input logic [COLOR_BITS-1:0] q,
                                                      input logic [COMP_BITS-1:0]  e);
    logic [COLOR_BITS-1:0] s;
    logic [COLOR_BITS-1:0] d;
    s = {e, 2'b00};
    d = (q >= s) ? (q - s) : (s - q);
    return d * d;
  endfunction

  entry_t                  mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] vld_r;
  entry_t                  rd_data_r;
  logic                    rd_vld_r;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_en;
  logic                    wr_ok;
  entry_t                  ent;

  item_t                   item_r;
  logic [IDX_W-1:0]        scan_cnt_r;
  logic                    s1_v_r;
  logic [IDX_W-1:0]        s1_idx_r;
  logic                    s2_v_r;
  logic [IDX_W-1:0]        s2_idx_r;
  logic [2*COLOR_BITS-1:0] sq_r [3];
  logic                    s3_v_r;
  logic [IDX_W-1:0]        s3_idx_r;
  logic [DIST_BITS-1:0]    sum_r;
  logic                    first_r;
  logic [DIST_BITS-1:0]    best_d_r;
  logic [IDX_W-1:0]        best_i_r;
  logic                    out_valid_r;
  res_t                    out_res_r;
  res_t                    out_res_nxt;
  logic                    item_in_range;

  assign wr_ok   = cmd.wr_en && ({1'b0, in_item.entry_index} < ENTRY_LIMIT);
  assign rd_en   = cmd.scan_rd || cmd.rd_item;
  assign rd_addr = cmd.scan_rd ? scan_cnt_r : item_r.entry_index[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[in_item.entry_index[IDX_W-1:0]] <= '{red:   in_item.entry_red,
                                               green: in_item.entry_green,
                                               blue:  in_item.entry_blue};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // never-written entries read as black
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_r[in_item.entry_index[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign ent = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  // scan pipeline: read, squares, sum, compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      first_r    <= 1'b1;
    end else begin
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end
      s1_v_r <= cmd.scan_rd;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (cmd.scan_clr) begin
        first_r <= 1'b1;
      end else if (s3_v_r) begin
        first_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= scan_cnt_r;
    s2_idx_r <= s1_idx_r;
    sq_r[0]  <= sq_diff(item_r.query_red, ent.red);
    sq_r[1]  <= sq_diff(item_r.query_green, ent.green);
    sq_r[2]  <= sq_diff(item_r.query_blue, ent.blue);
    s3_idx_r <= s2_idx_r;
    sum_r    <= DIST_BITS'(sq_r[0]) + DIST_BITS'(sq_r[1]) + DIST_BITS'(sq_r[2]);
    // strict compare keeps the lowest index on ties
    if (s3_v_r && (first_r || (sum_r < best_d_r))) begin
      best_d_r <= sum_r;
      best_i_r <= s3_idx_r;
    end
  end

  assign item_in_range = ({1'b0, item_r.entry_index} < ENTRY_LIMIT);

  always_comb begin
    out_res_nxt = '0;
    if (cmd.out_query) begin
      out_res_nxt.best_index = IDX_BITS'(best_i_r);
      out_res_nxt.match_dist = best_d_r;
    end else if (item_in_range) begin
      out_res_nxt.color_red   = {ent.red, 2'b00};
      out_res_nxt.color_green = {ent.green, 2'b00};
      out_res_nxt.color_blue  = {ent.blue, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_res        = out_res_r;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign stat.scan_last = (scan_cnt_r == LAST_IDX);

endmodule

// File: hw/rtl/npcs_ctrl.sv
// ----------------------------------------------------------------------------
// npcs_ctrl
// request sequencing: write, read and palette scan control
// ----------------------------------------------------------------------------
module npcs_ctrl
  import npcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [CMD_BITS-1:0] in_cmd,
  output logic                in_ready,
  input  dp_stat_t            stat,
  output ctrl_cmd_t           cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_cmd)
            CMD_WRITE: cmd.wr_en = 1'b1;
            CMD_READ:  state_nxt = ST_READ;
            CMD_QUERY: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ST_SCAN;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = ST_READ_OUT;
      end
      ST_READ_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_QUERY_OUT;
        end
      end
      ST_QUERY_OUT: begin
        cmd.out_query = 1'b1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register occupied");

  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !stat.pipe_busy)
    else $error("result loaded while scan pipeline still busy");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_clr |=> (state_r == ST_SCAN) && !stat.pipe_busy)
    else $error("query did not start a clean scan");
`endif

endmodule

// File: hw/rtl/nearest_palette_color_search_top.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// palette store with scaled readback and nearest color search
// ----------------------------------------------------------------------------
// One request is handled at a time. A write is stored as it is taken and
// gives no result; a read passes through ST_READ, which reads the entry,
// and ST_READ_OUT, which loads the result once the output register is
// free; a query scans the palette memory through its single read port, one
// entry per cycle, then drains a three-stage distance pipeline and loads
// its result in ST_QUERY_OUT once the output register is free, then takes
// the next request. The palette reads as all zero after reset through
// per-entry valid bits, so no clearing pass is needed. A finished result
// waits in the output register while the next request is taken.
module nearest_palette_color_search_top
  import npcs_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // entry_index, entry_red, entry_green, entry_blue, query_red, query_green,
  // query_blue, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic [CMD_BITS-1:0]    in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // best_index, match_dist, color_red, color_green, color_blue, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  item_t     in_item;
  res_t      out_res;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign in_item   = in_tdata[ITEM_W-1:0];
  assign out_tdata = {(OUT_TDATA_W-RES_W)'(0), out_res};

  npcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  npcs_dpath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

endmodule
